[hdl/css_pkg.sv]
// Shared types and constants of the cyclic shift sorter.
`timescale 1ns / 1ps
package css_pkg;

    // Text capacity and alphabet size
    localparam int MAX_TEXT = 1024;
    localparam int ALPHABET = 256;
    localparam int BUCKETS  = (MAX_TEXT > ALPHABET) ? MAX_TEXT : ALPHABET;

    // Index, count and bucket address widths
    localparam int IW  = $clog2(MAX_TEXT);
    localparam int CW  = IW + 1;
    localparam int SW  = CW + 1;
    localparam int BKW = $clog2(BUCKETS);

    // Item field widths
    localparam int BYTE_W  = 8;
    localparam int RANK_W  = 10;
    localparam int POS_W   = 10;
    localparam int COUNT_W = 11;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed {
        op_t               operation;
        logic [BYTE_W-1:0] text_byte;
        logic              last_byte;
        logic [RANK_W-1:0] rank;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   start_position;
        logic [COUNT_W-1:0] distinct_count;
    } out_item_t;

    // Engine status toward the top level
    typedef struct packed {
        logic      idle;
        logic      res_valid;
        out_item_t res;
    } eng_stat_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_HIST_RD,
        ST_HIST_KEY,
        ST_HIST_WR,
        ST_SCAN_RD,
        ST_SCAN_WR,
        ST_PLACE_RD,
        ST_PLACE_KEY,
        ST_PLACE_WR,
        ST_RANK_RD,
        ST_RANK_TXT,
        ST_RANK_WR,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_CNT_RD,
        ST_CNT_CLS,
        ST_CNT_KEY,
        ST_CNT_WR,
        ST_MOVE_RD,
        ST_MOVE_CLS,
        ST_MOVE_KEY,
        ST_MOVE_WR,
        ST_CLS_RD,
        ST_CLS_LO,
        ST_CLS_HI,
        ST_CLS_WR,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_FIND_RD,
        ST_FIND_CLS,
        ST_FIND_CMP,
        ST_RESP
    } st_t;

    // Clamp a byte into the alphabet
    function automatic logic [BYTE_W-1:0] sat_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W:0] top;
        top = (BYTE_W+1)'(ALPHABET - 1);
        if ({1'b0, b} > top)
            return top[BYTE_W-1:0];
        return b;
    endfunction

endpackage

[hdl/css_if.sv]
// Request and response channel interfaces of the cyclic shift sorter.
`timescale 1ns / 1ps
interface css_req_if;
    import css_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

interface css_rsp_if;
    import css_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

[hdl/css_ram.sv]
// Single write port, single read port memory with registered read data.
`timescale 1ns / 1ps
module css_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[hdl/css_engine.sv]
// Sort sequencer and rotation stores: loads text, sorts rotations, answers rank queries.
`timescale 1ns / 1ps
module css_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  css_pkg::in_item_t cmd,
    input  logic              res_ready,
    output css_pkg::eng_stat_t stat
);
    import css_pkg::*;

    // Memory ports
    logic              txt_we;
    logic [IW-1:0]     txt_wa, txt_ra;
    logic [BYTE_W-1:0] txt_wd, txt_rd;
    logic              ord_we;
    logic [IW-1:0]     ord_wa, ord_ra, ord_wd, ord_rd;
    logic              cls_we;
    logic [IW-1:0]     cls_wa, cls_ra, cls_wd, cls_rd;
    logic              ncl_we;
    logic [IW-1:0]     ncl_wa, ncl_ra, ncl_wd, ncl_rd;
    logic              obs_we;
    logic [IW-1:0]     obs_wa, obs_ra, obs_wd, obs_rd;
    logic              bkt_we;
    logic [BKW-1:0]    bkt_wa, bkt_ra;
    logic [CW-1:0]     bkt_wd, bkt_rd;

    // Control state
    st_t           state_reg, state_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] total_reg, total_next;
    logic [SW-1:0] step_reg, step_next;
    logic          closed_reg, closed_next;
    logic          first_reg, first_next;

    // Working data
    logic [CW-1:0]     run_reg, run_next;
    logic [BKW-1:0]    key_reg, key_next;
    logic [IW-1:0]     pos_reg, pos_next;
    logic [IW-1:0]     cnt_reg, cnt_next;
    logic [IW-1:0]     c1_reg, c1_next;
    logic [IW-1:0]     p1_reg, p1_next;
    logic [IW-1:0]     p2_reg, p2_next;
    logic [BYTE_W-1:0] prev_reg, prev_next;
    logic [RANK_W-1:0] k_reg, k_next;
    logic              found_reg, found_next;
    logic [IW-1:0]     fpos_reg, fpos_next;

    // Loop helpers
    logic          sweep;
    logic [CW-1:0] lim;
    logic [CW-1:0] i_inc;
    logic          last;
    logic [SW-1:0] sh_sum, sh_val, wr_sum, wr_val, step_dbl;
    logic [CW-1:0] eff_len;
    logic [IW-1:0] ncls;

    css_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_TEXT)) u_txt (
        .clk(clk), .we(txt_we), .waddr(txt_wa), .wdata(txt_wd), .raddr(txt_ra), .rdata(txt_rd)
    );
    css_ram #(.WIDTH(IW), .DEPTH(MAX_TEXT)) u_ord (
        .clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd), .raddr(ord_ra), .rdata(ord_rd)
    );
    css_ram #(.WIDTH(IW), .DEPTH(MAX_TEXT)) u_cls (
        .clk(clk), .we(cls_we), .waddr(cls_wa), .wdata(cls_wd), .raddr(cls_ra), .rdata(cls_rd)
    );
    css_ram #(.WIDTH(IW), .DEPTH(MAX_TEXT)) u_ncl (
        .clk(clk), .we(ncl_we), .waddr(ncl_wa), .wdata(ncl_wd), .raddr(ncl_ra), .rdata(ncl_rd)
    );
    css_ram #(.WIDTH(IW), .DEPTH(MAX_TEXT)) u_obs (
        .clk(clk), .we(obs_we), .waddr(obs_wa), .wdata(obs_wd), .raddr(obs_ra), .rdata(obs_rd)
    );
    css_ram #(.WIDTH(CW), .DEPTH(BUCKETS)) u_bkt (
        .clk(clk), .we(bkt_we), .waddr(bkt_wa), .wdata(bkt_wd), .raddr(bkt_ra), .rdata(bkt_rd)
    );

    // Loop bound: bucket sweeps of the first pass cover the alphabet
    assign sweep = (state_reg == ST_CLEAR) || (state_reg == ST_SCAN_RD)
                || (state_reg == ST_SCAN_WR);
    assign lim   = (sweep && first_reg) ? CW'(ALPHABET) : len_reg;
    assign i_inc = i_reg + 1'b1;
    assign last  = (i_inc == lim);

    // Rotation start shifted back by the step, modulo the length
    assign sh_sum = SW'(ord_rd) + SW'(len_reg) - step_reg;
    assign sh_val = (sh_sum >= SW'(len_reg)) ? sh_sum - SW'(len_reg) : sh_sum;
    // Second half start, modulo the length
    assign wr_sum = SW'(pos_reg) + step_reg;
    assign wr_val = (wr_sum >= SW'(len_reg)) ? wr_sum - SW'(len_reg) : wr_sum;
    assign step_dbl = step_reg << 1;

    assign eff_len = closed_reg ? '0 : len_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            i_reg      <= '0;
            len_reg    <= '0;
            total_reg  <= '0;
            step_reg   <= '0;
            closed_reg <= 1'b0;
            first_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            len_reg    <= len_next;
            total_reg  <= total_next;
            step_reg   <= step_next;
            closed_reg <= closed_next;
            first_reg  <= first_next;
        end
    end

    // Working data registers
    always_ff @(posedge clk)
    begin
        run_reg   <= run_next;
        key_reg   <= key_next;
        pos_reg   <= pos_next;
        cnt_reg   <= cnt_next;
        c1_reg    <= c1_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        prev_reg  <= prev_next;
        k_reg     <= k_next;
        found_reg <= found_next;
        fpos_reg  <= fpos_next;
    end

    // Sequencer: next state, memory accesses
    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        len_next    = len_reg;
        total_next  = total_reg;
        step_next   = step_reg;
        closed_next = closed_reg;
        first_next  = first_reg;
        run_next    = run_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        c1_next     = c1_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        prev_next   = prev_reg;
        k_next      = k_reg;
        found_next  = found_reg;
        fpos_next   = fpos_reg;
        ncls        = cnt_reg;

        txt_we = 1'b0; txt_wa = i_reg[IW-1:0]; txt_wd = '0; txt_ra = i_reg[IW-1:0];
        ord_we = 1'b0; ord_wa = i_reg[IW-1:0]; ord_wd = '0; ord_ra = i_reg[IW-1:0];
        cls_we = 1'b0; cls_wa = i_reg[IW-1:0]; cls_wd = '0; cls_ra = i_reg[IW-1:0];
        ncl_we = 1'b0; ncl_wa = i_reg[IW-1:0]; ncl_wd = '0; ncl_ra = i_reg[IW-1:0];
        obs_we = 1'b0; obs_wa = i_reg[IW-1:0]; obs_wd = '0; obs_ra = i_reg[IW-1:0];
        bkt_we = 1'b0; bkt_wa = i_reg[BKW-1:0]; bkt_wd = '0; bkt_ra = i_reg[BKW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.operation == OP_LOAD)
                    begin
                        // Append the byte; a closed text restarts from empty
                        len_next    = eff_len;
                        closed_next = 1'b0;
                        if (closed_reg)
                        begin
                            total_next = '0;
                        end
                        if (eff_len < CW'(MAX_TEXT))
                        begin
                            txt_we   = 1'b1;
                            txt_wa   = eff_len[IW-1:0];
                            txt_wd   = sat_byte(cmd.text_byte);
                            len_next = eff_len + 1'b1;
                        end
                        if (cmd.last_byte)
                        begin
                            closed_next = 1'b1;
                            first_next  = 1'b1;
                            i_next      = '0;
                            state_next  = ST_CLEAR;
                        end
                    end
                    else
                    begin
                        k_next = cmd.rank;
                        i_next = '0;
                        if (CW'(cmd.rank) < total_reg)
                        begin
                            state_next = ST_FIND_RD;
                        end
                        else
                        begin
                            found_next = 1'b0;
                            fpos_next  = '0;
                            state_next = ST_RESP;
                        end
                    end
                end
            end

            // Zero the buckets
            ST_CLEAR:
            begin
                bkt_we = 1'b1;
                if (last)
                begin
                    i_next     = '0;
                    state_next = first_reg ? ST_HIST_RD : ST_CNT_RD;
                end
                else
                begin
                    i_next = i_inc;
                end
            end

            // Count first bytes
            ST_HIST_RD:
            begin
                state_next = ST_HIST_KEY;
            end
            ST_HIST_KEY:
            begin
                key_next   = BKW'(txt_rd);
                bkt_ra     = BKW'(txt_rd);
                state_next = ST_HIST_WR;
            end
            ST_HIST_WR:
            begin
                bkt_we = 1'b1;
                bkt_wa = key_reg;
                bkt_wd = bkt_rd + 1'b1;
                if (last)
                begin
                    i_next     = '0;
                    run_next   = '0;
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = ST_HIST_RD;
                end
            end

            // Turn counts into bucket starts
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_WR;
            end
            ST_SCAN_WR:
            begin
                bkt_we   = 1'b1;
                bkt_wd   = run_reg;
                run_next = run_reg + bkt_rd;
                if (last)
                begin
                    i_next     = '0;
                    state_next = first_reg ? ST_PLACE_RD : ST_MOVE_RD;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = ST_SCAN_RD;
                end
            end

            // Place rotations by first byte
            ST_PLACE_RD:
            begin
                state_next = ST_PLACE_KEY;
            end
            ST_PLACE_KEY:
            begin
                key_next   = BKW'(txt_rd);
                bkt_ra     = BKW'(txt_rd);
                state_next = ST_PLACE_WR;
            end
            ST_PLACE_WR:
            begin
                ord_we = 1'b1;
                ord_wa = bkt_rd[IW-1:0];
                ord_wd = i_reg[IW-1:0];
                bkt_we = 1'b1;
                bkt_wa = key_reg;
                bkt_wd = bkt_rd + 1'b1;
                if (last)
                begin
                    i_next     = '0;
                    cnt_next   = '0;
                    state_next = ST_RANK_RD;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = ST_PLACE_RD;
                end
            end

            // Initial classes from first bytes
            ST_RANK_RD:
            begin
                state_next = ST_RANK_TXT;
            end
            ST_RANK_TXT:
            begin
                pos_next   = ord_rd;
                txt_ra     = ord_rd;
                state_next = ST_RANK_WR;
            end
            ST_RANK_WR:
            begin
                if ((i_reg != '0) && (txt_rd != prev_reg))
                begin
                    ncls = cnt_reg + 1'b1;
                end
                cls_we    = 1'b1;
                cls_wa    = pos_reg;
                cls_wd    = ncls;
                cnt_next  = ncls;
                prev_next = txt_rd;
                if (last)
                begin
                    i_next     = '0;
                    step_next  = SW'(1);
                    first_next = 1'b0;
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = ST_RANK_RD;
                end
            end

            // Order by second half
            ST_SHIFT_RD:
            begin
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                obs_we = 1'b1;
                obs_wd = sh_val[IW-1:0];
                if (last)
                begin
                    i_next     = '0;
                    state_next = ST_CLEAR;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = ST_SHIFT_RD;
                end
            end

            // Count classes of first halves
            ST_CNT_RD:
            begin
                state_next = ST_CNT_CLS;
            end
            ST_CNT_CLS:
            begin
                cls_ra     = obs_rd;
                state_next = ST_CNT_KEY;
            end
            ST_CNT_KEY:
            begin
                key_next   = BKW'(cls_rd);
                bkt_ra     = BKW'(cls_rd);
                state_next = ST_CNT_WR;
            end
            ST_CNT_WR:
            begin
                bkt_we = 1'b1;
                bkt_wa = key_reg;
                bkt_wd = bkt_rd + 1'b1;
                if (last)
                begin
                    i_next     = '0;
                    run_next   = '0;
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = ST_CNT_RD;
                end
            end

            // Stable placement by first-half class
            ST_MOVE_RD:
            begin
                state_next = ST_MOVE_CLS;
            end
            ST_MOVE_CLS:
            begin
                pos_next   = obs_rd;
                cls_ra     = obs_rd;
                state_next = ST_MOVE_KEY;
            end
            ST_MOVE_KEY:
            begin
                key_next   = BKW'(cls_rd);
                bkt_ra     = BKW'(cls_rd);
                state_next = ST_MOVE_WR;
            end
            ST_MOVE_WR:
            begin
                ord_we = 1'b1;
                ord_wa = bkt_rd[IW-1:0];
                ord_wd = pos_reg;
                bkt_we = 1'b1;
                bkt_wa = key_reg;
                bkt_wd = bkt_rd + 1'b1;
                if (last)
                begin
                    i_next     = '0;
                    cnt_next   = '0;
                    state_next = ST_CLS_RD;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = ST_MOVE_RD;
                end
            end

            // New classes from class pairs
            ST_CLS_RD:
            begin
                state_next = ST_CLS_LO;
            end
            ST_CLS_LO:
            begin
                pos_next   = ord_rd;
                cls_ra     = ord_rd;
                state_next = ST_CLS_HI;
            end
            ST_CLS_HI:
            begin
                c1_next    = cls_rd;
                cls_ra     = wr_val[IW-1:0];
                state_next = ST_CLS_WR;
            end
            ST_CLS_WR:
            begin
                if ((i_reg != '0) && ((c1_reg != p1_reg) || (cls_rd != p2_reg)))
                begin
                    ncls = cnt_reg + 1'b1;
                end
                ncl_we   = 1'b1;
                ncl_wa   = pos_reg;
                ncl_wd   = ncls;
                cnt_next = ncls;
                p1_next  = c1_reg;
                p2_next  = cls_rd;
                if (last)
                begin
                    i_next     = '0;
                    state_next = ST_COPY_RD;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = ST_CLS_RD;
                end
            end

            // Copy new classes back, then double the step, or finish once the doubled step exceeds the length
            ST_COPY_RD:
            begin
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                cls_we = 1'b1;
                cls_wd = ncl_rd;
                if (last)
                begin
                    i_next = '0;
                    if (step_dbl <= SW'(len_reg))
                    begin
                        step_next  = step_dbl;
                        state_next = ST_SHIFT_RD;
                    end
                    else
                    begin
                        total_next = CW'(cnt_reg) + 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = ST_COPY_RD;
                end
            end

            // Walk the order for the first rotation of the wanted class
            ST_FIND_RD:
            begin
                state_next = ST_FIND_CLS;
            end
            ST_FIND_CLS:
            begin
                pos_next   = ord_rd;
                cls_ra     = ord_rd;
                state_next = ST_FIND_CMP;
            end
            ST_FIND_CMP:
            begin
                if (CW'(cls_rd) == CW'(k_reg))
                begin
                    found_next = 1'b1;
                    fpos_next  = pos_reg;
                    state_next = ST_RESP;
                end
                else if (last)
                begin
                    found_next = 1'b0;
                    fpos_next  = '0;
                    state_next = ST_RESP;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = ST_FIND_RD;
                end
            end

            // Hold the result until the output stage takes it
            ST_RESP:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign stat.idle                    = (state_reg == ST_IDLE);
    assign stat.res_valid               = (state_reg == ST_RESP);
    assign stat.res.found               = found_reg;
    assign stat.res.start_position      = POS_W'(fpos_reg);
    assign stat.res.distinct_count      = COUNT_W'(total_reg);

`ifndef ASSERT_OFF
    // Distinct rotations never outnumber the text bytes
    a_total_le_len: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= len_reg)
        else $error("distinct count exceeds text length");

    // A found rotation starts inside the text
    a_pos_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESP && found_reg) |-> (CW'(fpos_reg) < len_reg))
        else $error("start position outside text");

    // Every rank below the distinct count has a rotation
    a_rank_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESP && CW'(k_reg) < total_reg) |-> found_reg)
        else $error("valid rank not found");
`endif

endmodule

[hdl/cyclic_shift_sorter.sv]
// Top level of the cyclic shift sorter: channel handshakes and result register.
`timescale 1ns / 1ps
// Load items are taken back to back and each appends a byte to the text (up to 1024 bytes, extra
// bytes dropped); the item flagged last_byte closes the text and starts the sort, during
// which no item is accepted. All working arrays sit in memories with one read port and
// registered read data, so every sort step walks them one entry at a time: a first pass, then
// floor(log2 n) + 1 doubling passes for a text of n bytes.
// A query walks the sorted order one entry at a time until the wanted class appears; a rank
// at or above the distinct count answers without a walk.
// A result sits in an output register, so the next item is taken while it waits.
module cyclic_shift_sorter (
    input  logic      clk,
    input  logic      rst_n,
    css_req_if.sink   req,
    css_rsp_if.source rsp
);
    import css_pkg::*;

    eng_stat_t stat;
    logic      res_ready;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg;

    css_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (req.valid && req.ready),
        .cmd       (req.data),
        .res_ready (res_ready),
        .stat      (stat)
    );

    // Take items only while the engine is idle
    assign req.ready = stat.idle;

    // Load the output register when it is empty or being drained
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (stat.res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result item
    always_ff @(posedge clk)
    begin
        if (stat.res_valid && res_ready)
        begin
            out_data_reg <= stat.res;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

endmodule

[tb/sv/css_checker.sv]
// Checker for the cyclic shift sorter: rotation-rank predictor and result comparison.
`timescale 1ns / 1ps
module css_checker (
    input  logic          clk,
    input  logic          rst_n,
    css_req_if.monitor    req_mon,
    css_rsp_if.monitor    rsp_mon,
    output int            fail_count,
    output int            pending
);
    import css_pkg::*;

    // Predictor copy of the text and its sorted rotations
    logic [BYTE_W-1:0] text_copy [MAX_TEXT];
    int                rot_order [MAX_TEXT];
    int                rot_class [MAX_TEXT];
    int                text_len;
    int                class_count;
    bit                text_done;
    out_item_t         expected_results [$];

    // Sort all rotations by prefix doubling and set rot_order / rot_class
    task automatic sort_rotations_model();
        int n, i, len, cls, a, b, s;
        int cnt [BUCKETS];
        int by_second [MAX_TEXT];
        int fresh [MAX_TEXT];
        n = text_len;
        if (n == 0)
        begin
            class_count = 0;
            return;
        end
        for (i = 0; i < BUCKETS; i++) cnt[i] = 0;
        for (i = 0; i < n; i++) cnt[text_copy[i]]++;
        s = 0;
        for (i = 0; i < ALPHABET; i++)
        begin
            a = cnt[i];
            cnt[i] = s;
            s += a;
        end
        for (i = 0; i < n; i++)
        begin
            a = cnt[text_copy[i]];
            rot_order[a] = i;
            cnt[text_copy[i]] = a + 1;
        end
        cls = 0;
        rot_class[rot_order[0]] = 0;
        for (i = 1; i < n; i++)
        begin
            if (text_copy[rot_order[i]] != text_copy[rot_order[i-1]]) cls++;
            rot_class[rot_order[i]] = cls;
        end
        cls++;
        for (len = 1; len <= n; len *= 2)
        begin
            for (i = 0; i < n; i++) by_second[i] = (rot_order[i] + n - len) % n;
            for (i = 0; i < BUCKETS; i++) cnt[i] = 0;
            for (i = 0; i < n; i++) cnt[rot_class[by_second[i]]]++;
            s = 0;
            for (i = 0; i < n; i++)
            begin
                a = cnt[i];
                cnt[i] = s;
                s += a;
            end
            for (i = 0; i < n; i++)
            begin
                b = by_second[i];
                a = cnt[rot_class[b]];
                rot_order[a] = b;
                cnt[rot_class[b]] = a + 1;
            end
            cls = 0;
            fresh[rot_order[0]] = 0;
            for (i = 1; i < n; i++)
            begin
                a = rot_order[i];
                b = rot_order[i-1];
                if (rot_class[a] != rot_class[b] ||
                    rot_class[(a + len) % n] != rot_class[(b + len) % n]) cls++;
                fresh[a] = cls;
            end
            cls++;
            for (i = 0; i < n; i++) rot_class[i] = fresh[i];
        end
        class_count = cls;
    endtask

    // Apply one accepted item to the predictor
    task automatic absorb_item(input in_item_t it);
        out_item_t r;
        int i;
        if (it.operation == OP_LOAD)
        begin
            if (text_done)
            begin
                text_done = 0;
                text_len = 0;
                class_count = 0;
            end
            if (text_len < MAX_TEXT)
            begin
                text_copy[text_len] = (int'(it.text_byte) >= ALPHABET) ?
                                      BYTE_W'(ALPHABET - 1) : it.text_byte;
                text_len++;
            end
            if (it.last_byte)
            begin
                text_done = 1;
                sort_rotations_model();
            end
        end
        else
        begin
            r = '0;
            if (int'(it.rank) < class_count)
            begin
                for (i = 0; i < text_len; i++)
                begin
                    if (rot_class[rot_order[i]] == int'(it.rank))
                    begin
                        r.found = 1'b1;
                        r.start_position = POS_W'(rot_order[i]);
                        break;
                    end
                end
            end
            r.distinct_count = COUNT_W'(class_count);
            expected_results.insert(expected_results.size(), r);
        end
    endtask

    // Watch both channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            text_len    <= 0;
            class_count <= 0;
            text_done   <= 0;
            fail_count  <= 0;
            pending     <= 0;
        end
        else
        begin
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, rsp_mon.data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_mon.data.found !== want.found ||
                        rsp_mon.data.start_position !== want.start_position ||
                        rsp_mon.data.distinct_count !== want.distinct_count)
                    begin
                        $display("%0t: mismatch, expected %p, actual %p",
                                 $time, want, rsp_mon.data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (req_mon.valid && req_mon.ready)
                absorb_item(req_mon.data);
            pending <= expected_results.size();
        end
    end

endmodule

[tb/sv/testbench.sv]
// Top of the cyclic shift sorter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import css_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    bit   quiet_mode;
    bit   hold_off;
    int   hold_left;
    bit   hold_done;

    css_req_if req ();
    css_rsp_if rsp ();

    cyclic_shift_sorter u_top (.clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source));

    css_checker u_chk (
        .clk(clk), .rst_n(rst_n), .req_mon(req.monitor), .rsp_mon(rsp.monitor),
        .fail_count(fail_count), .pending(pending)
    );

    // Clock
    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Send one item, idling at random beforehand
    task automatic send_item(input in_item_t it);
        while (!quiet_mode && $urandom_range(99) < 20)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= it;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_load(input int b, input bit last_flag);
        in_item_t it;
        it = '0;
        it.operation = OP_LOAD;
        it.text_byte = BYTE_W'(b);
        it.last_byte = last_flag;
        it.rank = RANK_W'($urandom);
        send_item(it);
    endtask

    task automatic send_query(input int k);
        in_item_t it;
        it = '0;
        it.operation = OP_QUERY;
        it.rank = RANK_W'(k);
        it.last_byte = 1'($urandom_range(1));
        it.text_byte = BYTE_W'($urandom);
        send_item(it);
    endtask

    // Load a random text of the given length over a small or full alphabet
    task automatic load_text(input int len, input int span);
        int i;
        for (i = 0; i < len; i++)
            send_load(span == 0 ? $urandom_range(255) : $urandom_range(span - 1), i == len - 1);
    endtask

    // Receiver: random stalls plus one long hold-off counted here
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_off && !hold_done)
        begin
            rsp.ready <= 1'b0;
            hold_left <= hold_left + 1;
            if (hold_left == 199)
                hold_done <= 1'b1;
        end
        else
            rsp.ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 20);
    end

    // Watchdog on cycles with no accepted item
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 600000)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        int i, t, len, span;
        req.valid = 1'b0;
        req.data = '0;
        rst_n = 1'b0;
        quiet_mode = 0;
        hold_off = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: query before any text, single byte, extremes, periodic text
        send_query(0);
        send_load(255, 1);
        send_query(0);
        send_query(1);
        send_query(1023);
        send_load(0, 0);
        send_query(0);
        send_load(0, 0);
        send_load(0, 1);
        send_query(0);
        send_query(1);
        send_load(8'hAA, 0);
        send_load(8'h55, 0);
        send_load(8'hAA, 0);
        send_load(8'h55, 1);
        send_query(0);
        send_query(1);
        send_query(2);
        send_load(3, 0);
        send_load(1, 0);
        send_load(2, 1);
        for (i = 0; i < 3; i++) send_query(i);

        // Long hold-off: queries pile up against a stalled receiver
        hold_off = 1;
        for (i = 0; i < 4; i++) send_query(i);

        // Random texts with random queries
        for (t = 0; t < 40; t++)
        begin
            quiet_mode = (t >= 15 && t < 20);
            len = (t == 39) ? 80 : $urandom_range(1, 12);
            span = $urandom_range(3) == 0 ? 0 : $urandom_range(2, 4);
            if (t == 39) span = 2;
            load_text(len, span);
            repeat ($urandom_range(3, 8))
            begin
                if ($urandom_range(9) == 0) send_query($urandom_range(1023));
                else send_query($urandom_range(len));
            end
        end
        quiet_mode = 0;

        // Last text ends with queries
        for (i = 0; i < 6; i++) send_query($urandom_range(1023));
        send_query(0);
        req.valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (3200) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

[cyclic_shift_sorter.f]
hdl/css_pkg.sv
hdl/css_if.sv
hdl/css_ram.sv
hdl/css_engine.sv
hdl/cyclic_shift_sorter.sv
tb/sv/css_checker.sv
tb/sv/testbench.sv
